[hdl/dvbe_pkg.sv]
// Package: shared types, constants and helper functions for date validation and BCD encoding.
`timescale 1ns / 1ps
`default_nettype none

package dvbe_pkg;

  // Configuration register map
  localparam int unsigned       RegCount   = 1;
  localparam int unsigned       AddrWidth  = 3;
  localparam logic              RegEpoch   = 1'b0;
  localparam logic [15:0]       EpochReset = 16'd2000;

  // Reciprocal for divisibility by 25 on 16-bit years: floor(n * 83887 / 2^21) == n / 25
  localparam logic [16:0]       Recip25    = 17'd83887;
  localparam int unsigned       Recip25Sh  = 21;

  // Reciprocal for division by 10 on 8-bit values: floor(n * 205 / 2^11) == n / 10
  localparam logic [7:0]        Recip10    = 8'd205;
  localparam int unsigned       Recip10Sh  = 11;

  // Validation limits
  localparam logic [4:0]        HourLimit  = 5'd24;
  localparam logic [5:0]        MinLimit   = 6'd60;
  localparam logic [3:0]        MonthMax   = 4'd12;
  localparam logic [3:0]        MonthFeb   = 4'd2;
  localparam logic [8:0]        OffsetMax  = 9'd255;
  localparam logic [7:0]        OffsetWrap = 8'd100;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_DATE   = 3'd1,
    ST_DAY_RANGE  = 3'd2,
    ST_BAD_TIME   = 3'd3,
    ST_YEAR_RANGE = 3'd4
  } status_e;

  // Validation outcome handed to the encoder
  typedef struct packed {
    status_e    status;
    logic [7:0] offset;
  } chk_t;

  // Encoded result fields
  typedef struct packed {
    logic [7:0] second;
    logic [7:0] minute;
    logic [7:0] hour;
    logic [7:0] day;
    logic [7:0] month;
    logic [7:0] year;
    logic [7:0] weekday;
  } bcd_t;

  // Days in each month, non-leap; zero for codes that are no month
  function automatic logic [4:0] month_len(input logic [3:0] mon);
    logic [4:0] len;
    case (mon)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Packed BCD of an 8-bit value; tens digit past 9 keeps its low four bits
  function automatic logic [7:0] to_bcd(input logic [7:0] v);
    logic [18:0] prod;
    logic [7:0]  tens;
    logic [7:0]  units;
    prod  = 19'(v) * 19'(Recip10);
    tens  = 8'(prod >> Recip10Sh);
    units = v - 8'(tens * 8'd10);
    return {tens[3:0], units[3:0]};
  endfunction

endpackage

`default_nettype wire

[hdl/dvbe_check.sv]
// Date and time range checks, Gregorian leap rule and year offset computation.
`timescale 1ns / 1ps
`default_nettype none

module dvbe_check import dvbe_pkg::*; (
  input  var logic [5:0]  second_i,
  input  var logic [5:0]  minute_i,
  input  var logic [4:0]  hour_i,
  input  var logic [4:0]  day_of_month_i,
  input  var logic [3:0]  month_i,
  input  var logic [15:0] full_year_i,
  input  var logic [15:0] epoch_year_i,
  output chk_t            chk_o
);

  logic [32:0] year_prod;
  logic [11:0] year_q25;
  logic [15:0] year_back;
  logic        div25;
  logic        div4;
  logic        div16;
  logic        leap;
  logic [5:0]  day_max;
  logic        bad_date;
  logic        day_over;
  logic        bad_time;
  logic [16:0] year_diff;
  logic        year_bad;
  logic [7:0]  offset;

  // Leap year: divisible by 4 and not by 100, or by 400 (400 = 16 * 25)
  assign year_prod = 33'(full_year_i) * 33'(Recip25);
  assign year_q25  = 12'(year_prod >> Recip25Sh);
  assign year_back = 16'({year_q25, 4'b0000}) + 16'({year_q25, 3'b000}) + 16'(year_q25);
  assign div25     = (year_back == full_year_i);
  assign div4      = (full_year_i[1:0] == 2'b00);
  assign div16     = (full_year_i[3:0] == 4'b0000);
  assign leap      = (div4 && !div25) || (div16 && div25);

  // Month length, with the extra day for February in a leap year
  assign day_max   = 6'(month_len(month_i)) + 6'((month_i == MonthFeb) && leap);

  assign bad_date  = (month_i == 4'd0) || (month_i > MonthMax) || (day_of_month_i == 5'd0);
  assign day_over  = (6'(day_of_month_i) > day_max);
  assign bad_time  = (hour_i >= HourLimit) || (minute_i >= MinLimit) || (second_i >= MinLimit);

  // Year offset from the epoch; a year before the epoch fails as well
  assign year_diff = 17'(full_year_i) - 17'(epoch_year_i);
  assign year_bad  = (full_year_i < epoch_year_i) || (year_diff[15:0] > 16'(OffsetMax));
  assign offset    = (year_diff[7:0] >= OffsetWrap) ? year_diff[7:0] - OffsetWrap
                                                    : year_diff[7:0];

  // Pick the first failing check
  always_comb begin
    chk_o.offset = offset;
    if (bad_date) begin
      chk_o.status = ST_BAD_DATE;
    end else if (day_over) begin
      chk_o.status = ST_DAY_RANGE;
    end else if (bad_time) begin
      chk_o.status = ST_BAD_TIME;
    end else if (year_bad) begin
      chk_o.status = ST_YEAR_RANGE;
    end else begin
      chk_o.status = ST_OK;
    end
  end

endmodule

`default_nettype wire

[hdl/dvbe_encode.sv]
// Binary to packed BCD conversion of every field, forced to zero on a failed check.
`timescale 1ns / 1ps
`default_nettype none

module dvbe_encode import dvbe_pkg::*; (
  input  var logic [5:0] second_i,
  input  var logic [5:0] minute_i,
  input  var logic [4:0] hour_i,
  input  var logic [4:0] day_of_month_i,
  input  var logic [3:0] month_i,
  input  var logic [2:0] weekday_i,
  input  var chk_t       chk_i,
  output bcd_t           bcd_o
);

  // Convert each field, drop everything on error
  always_comb begin
    if (chk_i.status == ST_OK) begin
      bcd_o.second  = to_bcd(8'(second_i));
      bcd_o.minute  = to_bcd(8'(minute_i));
      bcd_o.hour    = to_bcd(8'(hour_i));
      bcd_o.day     = to_bcd(8'(day_of_month_i));
      bcd_o.month   = to_bcd(8'(month_i));
      bcd_o.year    = to_bcd(chk_i.offset);
      bcd_o.weekday = to_bcd(8'(weekday_i));
    end else begin
      bcd_o = '0;
    end
  end

endmodule

`default_nettype wire

[hdl/datetime_validate_bcd_encode_top.sv]
// Top level: APB register, input register, check and encode logic, result register.
// A transaction is accepted on any clock where start_i is high; busy_o stays low, so a new
// date and time can be issued every cycle. The result is loaded into the result register at
// the clock edge after acceptance and sits on the result ports for the following cycle, marked
// by valid_o; it is taken while valid_o is high (one input register, one result
// register). The receiver cannot stall it and must take it then. status_o reports the first
// failing check, and all BCD fields are zero when status_o is nonzero. epoch_year sits at APB
// byte address 0 and may only be written while no transaction is in flight.
`timescale 1ns / 1ps
`default_nettype none

module datetime_validate_bcd_encode_top import dvbe_pkg::*; (
  input  var logic                 clk_i,
  input  var logic                 rst_ni,
  // APB configuration port
  input  var logic                 psel,
  input  var logic                 penable,
  input  var logic                 pwrite,
  input  var logic [AddrWidth-1:0] paddr,
  input  var logic [31:0]          pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  // Command side
  input  var logic                 start_i,
  output logic                     busy_o,
  input  var logic [5:0]           second_i,
  input  var logic [5:0]           minute_i,
  input  var logic [4:0]           hour_i,
  input  var logic [4:0]           day_of_month_i,
  input  var logic [3:0]           month_i,
  input  var logic [15:0]          full_year_i,
  input  var logic [2:0]           weekday_i,
  // Result side
  output logic                     valid_o,
  output logic [2:0]               status_o,
  output logic [7:0]               bcd_second_o,
  output logic [7:0]               bcd_minute_o,
  output logic [7:0]               bcd_hour_o,
  output logic [7:0]               bcd_day_o,
  output logic [7:0]               bcd_month_o,
  output logic [7:0]               bcd_year_o,
  output logic [7:0]               bcd_weekday_o
);

  logic [15:0] epoch_q;
  logic        reg_sel;
  logic        in_valid_q;
  logic [5:0]  second_q;
  logic [5:0]  minute_q;
  logic [4:0]  hour_q;
  logic [4:0]  day_q;
  logic [3:0]  month_q;
  logic [15:0] year_q;
  logic [2:0]  weekday_q;
  chk_t        chk;
  bcd_t        bcd;
  logic        out_valid_q;
  status_e     status_q;
  bcd_t        bcd_q;

  // Register access: one register, the rest of the map reads zero
  assign pready  = 1'b1;
  assign reg_sel = (paddr[AddrWidth-1:2] == RegEpoch);
  assign prdata  = reg_sel ? 32'(epoch_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_q <= EpochReset;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      epoch_q <= pwdata[15:0];
    end
  end

  // Never stalls: one transaction per cycle
  assign busy_o = 1'b0;

  // Capture the transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      second_q  <= second_i;
      minute_q  <= minute_i;
      hour_q    <= hour_i;
      day_q     <= day_of_month_i;
      month_q   <= month_i;
      year_q    <= full_year_i;
      weekday_q <= weekday_i;
    end
  end

  dvbe_check u_check (
    .second_i       (second_q),
    .minute_i       (minute_q),
    .hour_i         (hour_q),
    .day_of_month_i (day_q),
    .month_i        (month_q),
    .full_year_i    (year_q),
    .epoch_year_i   (epoch_q),
    .chk_o          (chk)
  );

  dvbe_encode u_encode (
    .second_i       (second_q),
    .minute_i       (minute_q),
    .hour_i         (hour_q),
    .day_of_month_i (day_q),
    .month_i        (month_q),
    .weekday_i      (weekday_q),
    .chk_i          (chk),
    .bcd_o          (bcd)
  );

  // Hold the result for its one-cycle strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      status_q <= chk.status;
      bcd_q    <= bcd;
    end
  end

  assign valid_o       = out_valid_q;
  assign status_o      = status_q;
  assign bcd_second_o  = bcd_q.second;
  assign bcd_minute_o  = bcd_q.minute;
  assign bcd_hour_o    = bcd_q.hour;
  assign bcd_day_o     = bcd_q.day;
  assign bcd_month_o   = bcd_q.month;
  assign bcd_year_o    = bcd_q.year;
  assign bcd_weekday_o = bcd_q.weekday;

endmodule

`default_nettype wire

[test/tb_datetime_validate_bcd_encode_top.sv]
// Testbench for the date and time checker with BCD encoding: directed and random traffic.
`timescale 1ns / 1ps

module tb_datetime_validate_bcd_encode_top;
  import dvbe_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam logic [AddrWidth-1:0] EpochAddr = AddrWidth'({RegEpoch, 2'b00});
  // byte address of register index 1, which does not exist
  localparam logic [AddrWidth-1:0] SpareAddr = AddrWidth'(4);

  typedef struct packed {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
    logic [2:0]  weekday;
  } date_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] second;
    logic [7:0] minute;
    logic [7:0] hour;
    logic [7:0] day;
    logic [7:0] month;
    logic [7:0] year;
    logic [7:0] weekday;
  } date_bcd_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [AddrWidth-1:0] paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 start_i = 1'b0;
  logic                 busy_o;
  date_t                date_drv = '0;
  logic                 valid_o;
  logic [2:0]           status_o;
  logic [7:0]           bcd_second_o;
  logic [7:0]           bcd_minute_o;
  logic [7:0]           bcd_hour_o;
  logic [7:0]           bcd_day_o;
  logic [7:0]           bcd_month_o;
  logic [7:0]           bcd_year_o;
  logic [7:0]           bcd_weekday_o;

  logic [15:0] epoch_year = EpochReset;
  date_bcd_t   pending_bcd[$];
  int unsigned errors = 0;
  bit          idle_enable = 1'b1;

  datetime_validate_bcd_encode_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .second_i       (date_drv.second),
    .minute_i       (date_drv.minute),
    .hour_i         (date_drv.hour),
    .day_of_month_i (date_drv.day),
    .month_i        (date_drv.month),
    .full_year_i    (date_drv.year),
    .weekday_i      (date_drv.weekday),
    .valid_o        (valid_o),
    .status_o       (status_o),
    .bcd_second_o   (bcd_second_o),
    .bcd_minute_o   (bcd_minute_o),
    .bcd_hour_o     (bcd_hour_o),
    .bcd_day_o      (bcd_day_o),
    .bcd_month_o    (bcd_month_o),
    .bcd_year_o     (bcd_year_o),
    .bcd_weekday_o  (bcd_weekday_o)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [7:0] bcd_byte(input int unsigned v);
    return 8'(((v / 10) << 4) + (v % 10));
  endfunction

  // Check a date against the calendar and the epoch window, then encode it
  function automatic date_bcd_t encode_date(input date_t d, input logic [15:0] epoch);
    date_bcd_t  r;
    logic       leap;
    logic [4:0] days;
    int         offset;
    r = '0;
    leap = ((d.year % 4 == 0) && (d.year % 100 != 0)) || (d.year % 400 == 0);
    case (d.month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: days = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    days = 5'd30;
      4'd2:                                       days = leap ? 5'd29 : 5'd28;
      default:                                    days = 5'd0;
    endcase
    offset = int'(d.year) - int'(epoch);
    if (d.month < 1 || d.month > 12 || d.day == 0) begin
      r.status = ST_BAD_DATE;
    end else if (d.day > days) begin
      r.status = ST_DAY_RANGE;
    end else if (d.hour >= 24 || d.minute >= 60 || d.second >= 60) begin
      r.status = ST_BAD_TIME;
    end else if (offset < 0 || offset > 255) begin
      r.status = ST_YEAR_RANGE;
    end else begin
      // subtract the century once only; 200..255 keep tens digits past nine
      if (offset >= 100) offset -= 100;
      r.status  = ST_OK;
      r.second  = bcd_byte(32'(d.second));
      r.minute  = bcd_byte(32'(d.minute));
      r.hour    = bcd_byte(32'(d.hour));
      r.day     = bcd_byte(32'(d.day));
      r.month   = bcd_byte(32'(d.month));
      r.year    = bcd_byte(unsigned'(offset));
      r.weekday = bcd_byte(32'(d.weekday));
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
    end
  endtask

  // Queue a prediction per accepted transaction and check each result strobe
  always @(posedge clk_i) begin : result_monitor
    date_bcd_t want;
    if (rst_ni && valid_o) begin
      if (pending_bcd.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, expected none actual status %h",
                 $time, status_o);
      end else begin
        want = pending_bcd.pop_front();
        check_field("status", 8'(want.status), 8'(status_o));
        check_field("bcd_second", want.second, bcd_second_o);
        check_field("bcd_minute", want.minute, bcd_minute_o);
        check_field("bcd_hour", want.hour, bcd_hour_o);
        check_field("bcd_day", want.day, bcd_day_o);
        check_field("bcd_month", want.month, bcd_month_o);
        check_field("bcd_year", want.year, bcd_year_o);
        check_field("bcd_weekday", want.weekday, bcd_weekday_o);
      end
    end
    if (rst_ni && start_i && !busy_o) pending_bcd.push_back(encode_date(date_drv, epoch_year));
  end

  // Drive one date, with an optional idle burst ahead of it, and hold until accepted
  task automatic send_date(input date_t d);
    int unsigned gap;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      repeat (gap) begin
        @(negedge clk_i);
        start_i = 1'b0;
      end
    end
    @(negedge clk_i);
    date_drv = d;
    start_i  = 1'b1;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic send_fields(input logic [5:0] s, input logic [5:0] mi, input logic [4:0] h,
                             input logic [4:0] d, input logic [3:0] mo, input logic [15:0] y,
                             input logic [2:0] w);
    date_t t;
    t = '{second: s, minute: mi, hour: h, day: d, month: mo, year: y, weekday: w};
    send_date(t);
  endtask

  // Drop start and wait for every outstanding result
  task automatic drain_results();
    @(negedge clk_i);
    start_i = 1'b0;
    while (pending_bcd.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Write a register over APB, then read the epoch back
  task automatic program_epoch(input logic [AddrWidth-1:0] addr, input logic [31:0] data);
    @(negedge clk_i);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = addr; pwdata = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == EpochAddr) epoch_year = data[15:0];
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    @(negedge clk_i);
    psel = 1'b1; paddr = EpochAddr;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[15:0] !== epoch_year) begin
      errors++;
      $display("%0t: epoch_year readback mismatch, expected %h actual %h",
               $time, epoch_year, prdata[15:0]);
    end
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0;
  endtask

  // Mostly well-formed dates near the epoch, some nudged out of the window, rest noise
  function automatic date_t random_date();
    date_t       d;
    int unsigned pick;
    d    = $bits(date_t)'({$urandom, $urandom});
    pick = $urandom_range(0, 99);
    if (pick < 85) begin
      d.second = 6'($urandom_range(0, 59));
      d.minute = 6'($urandom_range(0, 59));
      d.hour   = 5'($urandom_range(0, 23));
      d.month  = 4'($urandom_range(1, 12));
      d.day    = (pick < 12) ? 5'($urandom_range(29, 31)) : 5'($urandom_range(1, 28));
      d.year   = epoch_year + 16'($urandom_range(0, 255));
      if (pick < 6) begin
        d.month = 4'd2;
        d.day   = 5'd29;
        d.year  = 16'($urandom_range(0, 16383)) << 2;
      end else if (pick >= 75) begin
        d.year = (pick < 80) ? epoch_year - 16'($urandom_range(1, 3))
                             : epoch_year + 16'($urandom_range(256, 300));
      end
    end
    return d;
  endfunction

  // Calendar edges, every status and the century handling at the reset epoch
  task automatic test_calendar_limits();
    program_epoch(EpochAddr, 32'(EpochReset));
    send_fields(6'd0, 6'd0, 5'd0, 5'd0, 4'd0, 16'd0, 3'd0);
    send_fields(6'd63, 6'd63, 5'd31, 5'd31, 4'd15, 16'd65535, 3'd7);
    send_fields(6'd59, 6'd59, 5'd23, 5'd31, 4'd12, 16'd2255, 3'd7);
    send_fields(6'd0, 6'd0, 5'd0, 5'd1, 4'd1, 16'd2000, 3'd0);
    send_fields(6'd0, 6'd0, 5'd0, 5'd1, 4'd13, 16'd2000, 3'd0);
    send_fields(6'd0, 6'd0, 5'd0, 5'd0, 4'd5, 16'd2001, 3'd1);
    send_fields(6'd0, 6'd0, 5'd0, 5'd29, 4'd2, 16'd2000, 3'd1);
    send_fields(6'd0, 6'd0, 5'd0, 5'd29, 4'd2, 16'd2100, 3'd1);
    send_fields(6'd0, 6'd0, 5'd0, 5'd29, 4'd2, 16'd2004, 3'd2);
    send_fields(6'd0, 6'd0, 5'd0, 5'd29, 4'd2, 16'd2001, 3'd3);
    send_fields(6'd0, 6'd0, 5'd0, 5'd31, 4'd4, 16'd2001, 3'd4);
    send_fields(6'd0, 6'd0, 5'd0, 5'd30, 4'd4, 16'd2001, 3'd4);
    send_fields(6'd0, 6'd0, 5'd24, 5'd1, 4'd1, 16'd2001, 3'd5);
    send_fields(6'd0, 6'd60, 5'd0, 5'd1, 4'd1, 16'd2001, 3'd5);
    send_fields(6'd60, 6'd0, 5'd0, 5'd1, 4'd1, 16'd2001, 3'd6);
    send_fields(6'd0, 6'd0, 5'd0, 5'd1, 4'd1, 16'd1999, 3'd6);
    send_fields(6'd0, 6'd0, 5'd0, 5'd1, 4'd1, 16'd2256, 3'd6);
    send_fields(6'd0, 6'd0, 5'd0, 5'd1, 4'd1, 16'd2099, 3'd6);
    send_fields(6'd0, 6'd0, 5'd0, 5'd1, 4'd1, 16'd2100, 3'd6);
    send_fields(6'd0, 6'd0, 5'd0, 5'd1, 4'd1, 16'd2200, 3'd6);
    send_fields(6'd45, 6'd37, 5'd12, 5'd15, 4'd8, 16'd2023, 3'd3);
    drain_results();
  endtask

  // Epoch at both ends of its range, and a write to an unmapped register
  task automatic test_epoch_register();
    program_epoch(EpochAddr, 32'hFFFF_0000);
    send_fields(6'd0, 6'd0, 5'd0, 5'd29, 4'd2, 16'd0, 3'd0);
    send_fields(6'd59, 6'd59, 5'd23, 5'd31, 4'd12, 16'd255, 3'd7);
    send_fields(6'd0, 6'd0, 5'd0, 5'd1, 4'd1, 16'd256, 3'd0);
    drain_results();
    program_epoch(EpochAddr, 32'h0000_FFFF);
    send_fields(6'd0, 6'd0, 5'd0, 5'd1, 4'd1, 16'd65535, 3'd0);
    send_fields(6'd0, 6'd0, 5'd0, 5'd1, 4'd1, 16'd65534, 3'd0);
    drain_results();
    program_epoch(SpareAddr, 32'h0000_07D0);
    send_fields(6'd0, 6'd0, 5'd0, 5'd1, 4'd1, 16'd2000, 3'd0);
    drain_results();
  endtask

  // Random traffic over several epochs; the last phase runs without idle cycles
  task automatic test_random_traffic();
    logic [31:0] epochs[6];
    epochs = '{32'(EpochReset), 32'd0, $urandom, 32'd65280, $urandom, 32'd65535};
    foreach (epochs[p]) begin
      program_epoch(EpochAddr, epochs[p]);
      idle_enable = (p != 5);
      repeat (125) send_date(random_date());
      drain_results();
    end
  endtask

  // Abort on a hang
  initial begin : watchdog
    repeat (CycleLimit) @(posedge clk_i);
    $display("tb: failure");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_calendar_limits();
    test_epoch_register();
    test_random_traffic();
    if (pending_bcd.size() != 0) begin
      errors++;
      $display("%0t: results missing, expected %0d more actual 0", $time, pending_bcd.size());
    end
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
